/* rtl/http_request_header_tokenizer_macros.svh */
// Assertion macros shared by the tokenizer modules.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrt_pkg.sv */
// Shared types and constants for the HTTP request header tokenizer.
// No dependencies; used by every module of the block.
package hrt_pkg;

    localparam int unsigned METHOD_CAP   = 16;
    localparam int unsigned RESOURCE_CAP = 256;
    localparam int unsigned PROTOCOL_CAP = 16;
    localparam int unsigned NAME_CAP     = 64;
    localparam int unsigned VALUE_CAP    = 256;

    localparam int unsigned POS_SAT    = 256;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COLON = 8'h3a;

    localparam logic [2:0] K_METHOD   = 3'd0;
    localparam logic [2:0] K_RESOURCE = 3'd1;
    localparam logic [2:0] K_PROTOCOL = 3'd2;
    localparam logic [2:0] K_NAME     = 3'd3;
    localparam logic [2:0] K_VALUE    = 3'd4;
    localparam logic [2:0] K_END      = 3'd5;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       ch;
        logic [POS_W-1:0] pos;
        logic [7:0]       hidx;
        logic             fend;
    } token_t;

    function automatic logic [POS_W-1:0] cap_of(input logic [2:0] kind);
        logic [POS_W-1:0] cap;
        case (kind)
            K_METHOD:   cap = POS_W'(METHOD_CAP);
            K_RESOURCE: cap = POS_W'(RESOURCE_CAP);
            K_PROTOCOL: cap = POS_W'(PROTOCOL_CAP);
            K_NAME:     cap = POS_W'(NAME_CAP);
            default:    cap = POS_W'(VALUE_CAP);
        endcase
        return cap;
    endfunction

endpackage

/* rtl/hrt_front.sv */
// Front end: accepts request bytes, tracks the parse phase and classifies each byte.
// Depends on hrt_pkg and the assertion macro header; pushes tokens into hrt_fifo.
`include "http_request_header_tokenizer_macros.svh"

module hrt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      byte_in,
    input  logic            fifo_full,
    output logic            push,
    output hrt_pkg::token_t push_tok
);

    typedef enum logic [3:0] {
        PH_METHOD     = 4'd0,
        PH_RESOURCE   = 4'd1,
        PH_PROTOCOL   = 4'd2,
        PH_SKIP_PROTO = 4'd3,
        PH_LINE_START = 4'd4,
        PH_NAME       = 4'd5,
        PH_SKIP_COLON = 4'd6,
        PH_VALUE      = 4'd7,
        PH_SKIP_VALUE = 4'd8,
        PH_SKIP_END   = 4'd9
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [hrt_pkg::POS_W-1:0]    pos_reg, pos_next, pos_inc;
    logic [7:0]                   hcnt_reg, hcnt_next;
    logic                         accept;
    logic                         emit;
    logic                         is_end;
    logic [2:0]                   tok_kind;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign pos_inc  = (pos_reg < hrt_pkg::POS_W'(hrt_pkg::POS_SAT)) ? pos_reg + 1'b1 : pos_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hcnt_next  = hcnt_reg;
        emit       = 1'b0;
        is_end     = 1'b0;
        tok_kind   = hrt_pkg::K_METHOD;
        unique case (phase_reg)
            PH_METHOD:
            begin
                emit     = 1'b1;
                tok_kind = hrt_pkg::K_METHOD;
                is_end   = (byte_in == hrt_pkg::CH_SPACE);
                if (is_end)
                begin
                    phase_next = PH_RESOURCE;
                end
            end
            PH_RESOURCE:
            begin
                emit     = 1'b1;
                tok_kind = hrt_pkg::K_RESOURCE;
                is_end   = (byte_in == hrt_pkg::CH_SPACE);
                if (is_end)
                begin
                    phase_next = PH_PROTOCOL;
                end
            end
            PH_PROTOCOL:
            begin
                emit     = 1'b1;
                tok_kind = hrt_pkg::K_PROTOCOL;
                is_end   = (byte_in == hrt_pkg::CH_CR);
                if (is_end)
                begin
                    phase_next = PH_SKIP_PROTO;
                end
            end
            PH_SKIP_PROTO:
            begin
                phase_next = PH_LINE_START;
            end
            PH_LINE_START:
            begin
                emit = 1'b1;
                if (byte_in == hrt_pkg::CH_CR)
                begin
                    tok_kind   = hrt_pkg::K_END;
                    is_end     = 1'b1;
                    phase_next = PH_SKIP_END;
                end
                else
                begin
                    tok_kind   = hrt_pkg::K_NAME;
                    is_end     = (byte_in == hrt_pkg::CH_COLON);
                    phase_next = is_end ? PH_SKIP_COLON : PH_NAME;
                end
            end
            PH_NAME:
            begin
                emit     = 1'b1;
                tok_kind = hrt_pkg::K_NAME;
                is_end   = (byte_in == hrt_pkg::CH_COLON);
                if (is_end)
                begin
                    phase_next = PH_SKIP_COLON;
                end
            end
            PH_SKIP_COLON:
            begin
                phase_next = PH_VALUE;
            end
            PH_VALUE:
            begin
                emit     = 1'b1;
                tok_kind = hrt_pkg::K_VALUE;
                is_end   = (byte_in == hrt_pkg::CH_CR);
                if (is_end)
                begin
                    phase_next = PH_SKIP_VALUE;
                end
            end
            PH_SKIP_VALUE:
            begin
                if (hcnt_reg != 8'hff)
                begin
                    hcnt_next = hcnt_reg + 8'd1;
                end
                phase_next = PH_LINE_START;
            end
            PH_SKIP_END:
            begin
                hcnt_next  = '0;
                pos_next   = '0;
                phase_next = PH_METHOD;
            end
            default:
            begin
                hcnt_next  = '0;
                pos_next   = '0;
                phase_next = PH_METHOD;
            end
        endcase
        if (emit)
        begin
            pos_next = is_end ? '0 : pos_inc;
        end
    end

    always_comb
    begin
        push_tok.kind = tok_kind;
        push_tok.ch   = is_end ? 8'd0 : byte_in;
        push_tok.pos  = (tok_kind == hrt_pkg::K_END) ? '0 : pos_reg;
        push_tok.hidx = hcnt_reg;
        push_tok.fend = is_end;
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            pos_reg   <= '0;
            hcnt_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hcnt_reg  <= hcnt_next;
        end
    end

    `HRT_ASSERT_NOW(a_skip_no_token,
        accept && (phase_reg == PH_SKIP_PROTO || phase_reg == PH_SKIP_COLON ||
                   phase_reg == PH_SKIP_VALUE || phase_reg == PH_SKIP_END),
        !push, "skipped byte produced a token")

endmodule

/* rtl/hrt_fifo.sv */
// Short token queue between the classifying front end and the output stage.
// Depends on hrt_pkg and the assertion macro header.
`include "http_request_header_tokenizer_macros.svh"

module hrt_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hrt_pkg::token_t push_tok,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output hrt_pkg::token_t pop_tok
);

    hrt_pkg::token_t                   mem [hrt_pkg::FIFO_DEPTH];
    logic [hrt_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [hrt_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [hrt_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == hrt_pkg::FIFO_CNT_W'(hrt_pkg::FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_tok  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `HRT_ASSERT_NOW(a_no_overflow, push, !full, "token pushed into a full queue")
    `HRT_ASSERT_NOW(a_no_underflow, pop, nonempty, "token popped from an empty queue")
    `HRT_ASSERT_NEXT(a_count_up, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not follow a lone push")

endmodule

/* rtl/hrt_back.sv */
// Output stage: takes tokens from the queue, applies position saturation and capacity flags.
// Depends on hrt_pkg; drives the result channel of the top level.
module hrt_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            nonempty,
    input  hrt_pkg::token_t pop_tok,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      char_out,
    output logic [7:0]      position,
    output logic [7:0]      header_index,
    output logic            field_end,
    output logic            truncated
);

    logic       out_valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] char_reg;
    logic [7:0] pos_reg;
    logic [7:0] hidx_reg;
    logic       fend_reg;
    logic       trunc_reg;
    logic [7:0] pos_sat;
    logic       trunc_calc;

    assign pop        = nonempty && (!out_valid_reg || out_ready);
    assign pos_sat    = pop_tok.pos[hrt_pkg::POS_W-1] ? 8'hff : pop_tok.pos[7:0];
    assign trunc_calc = (pop_tok.kind != hrt_pkg::K_END) &&
                        (pop_tok.pos >= hrt_pkg::cap_of(pop_tok.kind));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= pop_tok.kind;
            char_reg  <= pop_tok.ch;
            pos_reg   <= pos_sat;
            hidx_reg  <= pop_tok.hidx;
            fend_reg  <= pop_tok.fend;
            trunc_reg <= trunc_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign char_out     = char_reg;
    assign position     = pos_reg;
    assign header_index = hidx_reg;
    assign field_end    = fend_reg;
    assign truncated    = trunc_reg;

endmodule

/* rtl/http_request_header_tokenizer.sv */
// Top level of the HTTP request header tokenizer: front end, token queue and output stage.
// Depends on hrt_pkg, hrt_front, hrt_fifo and hrt_back.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_ready    byte_in
//   result    out        out_valid/out_ready  kind, char_out, position, header_index,
//                                             field_end, truncated
//
// One byte is taken per cycle while the four-entry token queue has room.
// Each result passes through the token queue and then the output register.
// Skipped bytes leave no result. Reset clears the parse phase, counters and queue.
// A stalled result side fills the queue, after which in_ready falls until a transfer drains it.
module http_request_header_tokenizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] char_out,
    output logic [7:0] position,
    output logic [7:0] header_index,
    output logic       field_end,
    output logic       truncated
);

    logic            fifo_full;
    logic            fifo_nonempty;
    logic            push;
    logic            pop;
    hrt_pkg::token_t push_tok;
    hrt_pkg::token_t pop_tok;

    hrt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .fifo_full (fifo_full),
        .push      (push),
        .push_tok  (push_tok)
    );

    hrt_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .full     (fifo_full),
        .pop      (pop),
        .nonempty (fifo_nonempty),
        .pop_tok  (pop_tok)
    );

    hrt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .nonempty     (fifo_nonempty),
        .pop_tok      (pop_tok),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .char_out     (char_out),
        .position     (position),
        .header_index (header_index),
        .field_end    (field_end),
        .truncated    (truncated)
    );

endmodule
